// ----- rtl/udp_port_frame_classifier_defines.svh -----
// assertion macros used by the classifier request queue
`ifndef UDP_PORT_FRAME_CLASSIFIER_DEFINES_SVH
`define UDP_PORT_FRAME_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge out of reset
`define UPFC_ASSERT(name, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("upfc assertion failed");
// condition must never be seen out of reset
`define UPFC_NEVER(name, cond) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("upfc forbidden condition seen");
`else
`define UPFC_ASSERT(name, prop)
`define UPFC_NEVER(name, cond)
`endif

`endif

// ----- rtl/upfc_pkg.sv -----
`timescale 1ns / 1ps
package upfc_pkg;

    // receive queues with a socket mask bit each
    localparam int QUEUE_COUNT = 64;

    // ethernet / ip / udp constants
    localparam logic [15:0] KIND_IPV4    = 16'h0800;
    localparam logic [15:0] KIND_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [6:0]  ETH_LEN      = 7'd14;
    localparam logic [6:0]  IPV4_MIN_LEN = 7'd20;
    localparam logic [6:0]  IPV6_LEN     = 7'd40;
    localparam logic [6:0]  UDP_LEN      = 7'd8;

    // byte positions of fixed captures
    localparam logic [15:0] POS_KIND_HI  = 16'd12;
    localparam logic [15:0] POS_KIND_LO  = 16'd13;
    localparam logic [15:0] POS_IHL      = 16'd14;
    localparam logic [15:0] POS_V6_NEXT  = 16'd20;
    localparam logic [15:0] POS_V4_PROTO = 16'd23;
    localparam logic [15:0] COUNT_MAX    = 16'hFFFF;

    // configuration register indexes
    localparam logic CFG_MATCH_PORT  = 1'b0;
    localparam logic CFG_SOCKET_MASK = 1'b1;
    localparam logic [15:0] MATCH_PORT_RESET = 16'd53;

    // request queue between parser and judge
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic [5:0] rx_queue;
    } in_item_t;

    typedef struct packed {
        logic       verdict;
        logic [5:0] target_queue;
    } out_item_t;

    // per-frame request from parser to judge
    typedef struct packed {
        logic        candidate;
        logic [15:0] dest_port;
        logic [5:0]  rx_queue;
    } frame_req_t;

endpackage

// ----- rtl/udp_port_frame_classifier.sv -----
`timescale 1ns / 1ps
// Frame classifier: takes an Ethernet frame one byte per request, a new byte
// accepted every cycle while s_ready is high, and gives one verdict per frame
// via the request queue and the output register. A frame is redirected (verdict 1,
// target_queue = rx_queue) when it is IPv4 or IPv6 carrying UDP, holds the
// whole IP and UDP headers, its UDP destination port equals match_port
// (register 0, reset 53) and socket_mask (register 1, reset 0) has the bit
// for its queue; otherwise it is passed with target_queue 0. VLAN tags are
// not parsed. A two-entry request queue sits between the byte parser and the
// verdict stage, so s_ready drops only when two verdicts wait in the queue
// behind one that m_ready has not taken; the rate is otherwise set by the
// parser at one byte per cycle.
module udp_port_frame_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  upfc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output upfc_pkg::out_item_t m_data,
    input  logic                cfg_we,
    input  logic                cfg_addr,
    input  logic [63:0]         cfg_wdata
);

    logic                 in_accept;
    logic                 push;
    logic                 pop;
    logic                 fifo_full;
    logic                 fifo_empty;
    upfc_pkg::frame_req_t push_req;
    upfc_pkg::frame_req_t pop_req;

    assign s_ready   = !fifo_full;
    assign in_accept = s_valid && s_ready;

    // byte parser
    upfc_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (in_accept),
        .item    (s_data),
        .push    (push),
        .req     (push_req)
    );

    // frame request queue
    upfc_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .pop_req  (pop_req),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // verdict stage
    upfc_judge u_judge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req_valid (!fifo_empty),
        .req       (pop_req),
        .req_pop   (pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- rtl/upfc_parser.sv -----
`timescale 1ns / 1ps
module upfc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  upfc_pkg::in_item_t  item,
    output logic                push,
    output upfc_pkg::frame_req_t req
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [15:0] ether_kind_reg, ether_kind_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  next_protocol_reg, next_protocol_next;
    logic [15:0] dest_port_reg, dest_port_next;

    logic        is_v4;
    logic        is_v6;
    logic [6:0]  udp_start;
    logic [6:0]  udp_last;
    logic [6:0]  ip_last;
    logic [15:0] port_hi_pos;
    logic [15:0] port_lo_pos;

    // header geometry from captured fields
    always_comb begin
        is_v4 = (ether_kind_reg == upfc_pkg::KIND_IPV4);
        is_v6 = (ether_kind_reg == upfc_pkg::KIND_IPV6);
        if (is_v6) begin
            udp_start = upfc_pkg::ETH_LEN + upfc_pkg::IPV6_LEN;
            ip_last   = upfc_pkg::ETH_LEN + upfc_pkg::IPV6_LEN - 7'd1;
        end else begin
            udp_start = upfc_pkg::ETH_LEN + {1'b0, header_words_reg, 2'b00};
            ip_last   = upfc_pkg::ETH_LEN + upfc_pkg::IPV4_MIN_LEN - 7'd1;
        end
        udp_last    = udp_start + upfc_pkg::UDP_LEN - 7'd1;
        port_hi_pos = {9'd0, udp_start + 7'd2};
        port_lo_pos = {9'd0, udp_start + 7'd3};
    end

    // capture fields by byte position, clear on last byte
    always_comb begin
        byte_count_next    = byte_count_reg;
        ether_kind_next    = ether_kind_reg;
        header_words_next  = header_words_reg;
        next_protocol_next = next_protocol_reg;
        dest_port_next     = dest_port_reg;
        if (accept) begin
            if (item.last_byte) begin
                byte_count_next    = '0;
                ether_kind_next    = '0;
                header_words_next  = '0;
                next_protocol_next = '0;
                dest_port_next     = '0;
            end else begin
                if (byte_count_reg != upfc_pkg::COUNT_MAX) begin
                    byte_count_next = byte_count_reg + 16'd1;
                end
                if (byte_count_reg == upfc_pkg::POS_KIND_HI) begin
                    ether_kind_next = {item.frame_byte, ether_kind_reg[7:0]};
                end else if (byte_count_reg == upfc_pkg::POS_KIND_LO) begin
                    ether_kind_next = {ether_kind_reg[15:8], item.frame_byte};
                end
                if (is_v4 && byte_count_reg == upfc_pkg::POS_IHL) begin
                    header_words_next = item.frame_byte[3:0];
                end
                if ((is_v4 && byte_count_reg == upfc_pkg::POS_V4_PROTO) ||
                    (is_v6 && byte_count_reg == upfc_pkg::POS_V6_NEXT)) begin
                    next_protocol_next = item.frame_byte;
                end
                if (is_v4 || is_v6) begin
                    if (byte_count_reg == port_hi_pos) begin
                        dest_port_next = {item.frame_byte, dest_port_reg[7:0]};
                    end else if (byte_count_reg == port_lo_pos) begin
                        dest_port_next = {dest_port_reg[15:8], item.frame_byte};
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg    <= '0;
            ether_kind_reg    <= '0;
            header_words_reg  <= '0;
            next_protocol_reg <= '0;
            dest_port_reg     <= '0;
        end else begin
            byte_count_reg    <= byte_count_next;
            ether_kind_reg    <= ether_kind_next;
            header_words_reg  <= header_words_next;
            next_protocol_reg <= next_protocol_next;
            dest_port_reg     <= dest_port_next;
        end
    end

    // frame request on last byte: kind, protocol and length checks
    always_comb begin
        push              = accept && item.last_byte;
        req.candidate     = (is_v4 || is_v6) &&
                            (next_protocol_reg == upfc_pkg::PROTO_UDP) &&
                            (byte_count_reg >= {9'd0, ip_last}) &&
                            (byte_count_reg >= {9'd0, udp_last});
        req.dest_port     = dest_port_reg;
        req.rx_queue      = item.rx_queue;
    end

endmodule

// ----- rtl/upfc_fifo.sv -----
`timescale 1ns / 1ps
`include "udp_port_frame_classifier_defines.svh"
module upfc_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  upfc_pkg::frame_req_t push_req,
    input  logic                 pop,
    output upfc_pkg::frame_req_t pop_req,
    output logic                 full,
    output logic                 empty
);

    upfc_pkg::frame_req_t entry_reg [upfc_pkg::FIFO_DEPTH];
    logic [upfc_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [upfc_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [upfc_pkg::FIFO_CNT_W-1:0] count_reg, count_next;

    // pointer wrap at queue depth
    function automatic logic [upfc_pkg::FIFO_PTR_W-1:0] ptr_inc(
        input logic [upfc_pkg::FIFO_PTR_W-1:0] p);
        if (p == upfc_pkg::FIFO_PTR_W'(upfc_pkg::FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + upfc_pkg::FIFO_PTR_W'(1);
    endfunction

    assign full    = (count_reg == upfc_pkg::FIFO_CNT_W'(upfc_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_req = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + upfc_pkg::FIFO_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - upfc_pkg::FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // request storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_req;
        end
    end

    `UPFC_NEVER(a_fifo_overflow, push && full && !pop)
    `UPFC_NEVER(a_fifo_underflow, pop && empty)
    `UPFC_ASSERT(a_fifo_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1)
    `UPFC_ASSERT(a_fifo_ptr_gap, empty |-> wr_ptr_reg == rd_ptr_reg)

endmodule

// ----- rtl/upfc_judge.sv -----
`timescale 1ns / 1ps
module upfc_judge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [63:0]          cfg_wdata,
    input  logic                 req_valid,
    input  upfc_pkg::frame_req_t req,
    output logic                 req_pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output upfc_pkg::out_item_t  m_data
);

    logic [15:0] match_port_reg;
    logic [63:0] socket_mask_reg;
    logic        m_valid_reg, m_valid_next;
    upfc_pkg::out_item_t m_data_reg, m_data_next;
    logic        hit;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_port_reg  <= upfc_pkg::MATCH_PORT_RESET;
            socket_mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                upfc_pkg::CFG_MATCH_PORT:  match_port_reg  <= cfg_wdata[15:0];
                upfc_pkg::CFG_SOCKET_MASK: socket_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // port match and bound socket check, output register
    always_comb begin
        hit = req.candidate &&
              (req.dest_port == match_port_reg) &&
              ({1'b0, req.rx_queue} < 7'(upfc_pkg::QUEUE_COUNT)) &&
              socket_mask_reg[req.rx_queue];
        req_pop      = req_valid && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (req_pop) begin
            m_valid_next             = 1'b1;
            m_data_next.verdict      = hit;
            m_data_next.target_queue = hit ? req.rx_queue : 6'd0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
